@@ src/tdsppm_pkg.sv @@
// shared types, widths and codes for the temperature compensated tds unit
package tdsppm_pkg;

    // input field widths
    localparam int VOLT_BITS = 12;
    localparam int TEMP_BITS = 12;
    // 400 + temperature stays within 1..2447 when positive
    localparam int D_BITS    = 12;
    localparam int D_REF     = 400;

    // configuration registers
    localparam int CUBIC_W   = 16;
    localparam int SQUARE_W  = 16;
    localparam int LINEAR_W  = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CUBIC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 2'd2;

    localparam logic [CUBIC_W-1:0]  CUBIC_RST  = 16'd13342;
    localparam logic [SQUARE_W-1:0] SQUARE_RST = 16'd25586;
    localparam logic [LINEAR_W-1:0] LINEAR_RST = 17'd85739;

    // result fields
    localparam int PPM_W  = 16;
    localparam int COND_W = 17;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_VOLT_BAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TEMP_BAD = 2'd2;

    // ppm = round(v * p / (6250 * d^3)),
    // p = 16*a*v^2 - 20*b*v*d + 25*l*d^2
    localparam int VV_W  = 2 * VOLT_BITS;
    localparam int VD_W  = VOLT_BITS + D_BITS;
    localparam int DD_W  = 2 * D_BITS;
    localparam int D3_W  = 3 * D_BITS;
    localparam int TA_W  = CUBIC_W + VV_W;
    localparam int TB_W  = SQUARE_W + VD_W;
    localparam int TL_W  = LINEAR_W + DD_W;
    localparam int PA_W  = ((TA_W + 4 > TL_W + 5) ? TA_W + 4 : TL_W + 5) + 1;
    localparam int PB_W  = TB_W + 5;
    localparam int CMP_W = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int P_W   = PA_W;
    localparam int P_LO_W = 32;
    localparam int P_HI_W = P_W - P_LO_W;
    localparam int MLO_W = VOLT_BITS + P_LO_W;
    localparam int MHI_W = VOLT_BITS + P_HI_W;
    localparam int NUM_W = VOLT_BITS + P_W;
    localparam int DEN_SCALE = 6250;
    localparam int DEN_W = D3_W + 13;
    localparam int T_W   = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1;
    localparam int R_W   = (T_W > DEN_W + PPM_W + 1) ? T_W : DEN_W + PPM_W + 1;

    localparam int POLY_STAGES = 8;
    localparam int DIV_STAGES  = PPM_W + 2;

    typedef struct packed {
        logic [VOLT_BITS-1:0]        volts_mv;
        logic                        volts_valid;
        logic signed [TEMP_BITS-1:0] temp_sixteenths;
        logic                        temp_valid;
    } sample_t;

    typedef struct packed {
        logic [PPM_W-1:0]  ppm_out;
        logic [COND_W-1:0] conductivity_us;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [CUBIC_W-1:0]  cubic;
        logic [SQUARE_W-1:0] square;
        logic [LINEAR_W-1:0] linear;
    } coef_t;

    // rounding dividend t = 2*v*p + den, quotient t / (2*den)
    typedef struct packed {
        logic [T_W-1:0]    t;
        logic [DEN_W-1:0]  den;
        logic [STAT_W-1:0] status;
    } frac_t;

endpackage

@@ src/tdsppm_poly.sv @@
// compensation and cubic pipeline, produces the rounding dividend and divisor
module tdsppm_poly
(
    input  logic                clk,
    input  logic                rst_n,
    input  tdsppm_pkg::coef_t   coef,
    input  tdsppm_pkg::sample_t sample,
    input  logic                sample_valid,
    output logic                sample_ready,
    output tdsppm_pkg::frac_t   frac,
    output logic                frac_valid,
    input  logic                frac_ready
);

    localparam int N   = tdsppm_pkg::POLY_STAGES;
    localparam int VB  = tdsppm_pkg::VOLT_BITS;
    localparam int DB  = tdsppm_pkg::D_BITS;
    localparam int SW  = tdsppm_pkg::STAT_W;
    localparam int TW2 = tdsppm_pkg::TEMP_BITS + 2;

    logic [N-1:0] vld_reg;
    logic [N:0]   adv;

    // stage registers
    logic [VB-1:0] v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DB-1:0] d0_reg, d1_reg;
    logic [SW-1:0] st_reg [N];
    logic [tdsppm_pkg::VV_W-1:0]  vv1_reg;
    logic [tdsppm_pkg::VD_W-1:0]  vd1_reg;
    logic [tdsppm_pkg::DD_W-1:0]  dd1_reg;
    logic [tdsppm_pkg::TA_W-1:0]  ta2_reg;
    logic [tdsppm_pkg::TB_W-1:0]  tb2_reg;
    logic [tdsppm_pkg::TL_W-1:0]  tl2_reg;
    logic [tdsppm_pkg::D3_W-1:0]  d3_2_reg;
    logic [tdsppm_pkg::PA_W-1:0]  pa3_reg;
    logic [tdsppm_pkg::PB_W-1:0]  pb3_reg;
    logic [tdsppm_pkg::DEN_W-1:0] den3_reg, den4_reg, den5_reg, den6_reg, den7_reg;
    logic [tdsppm_pkg::P_W-1:0]   p4_reg;
    logic [tdsppm_pkg::MLO_W-1:0] mlo5_reg;
    logic [tdsppm_pkg::MHI_W-1:0] mhi5_reg;
    logic [tdsppm_pkg::NUM_W-1:0] num6_reg;
    logic [tdsppm_pkg::T_W-1:0]   t7_reg;

    // next values
    logic signed [TW2-1:0] temp_sel, d_s;
    logic [SW-1:0] st0_next;
    logic [tdsppm_pkg::VV_W-1:0]  vv1_next;
    logic [tdsppm_pkg::VD_W-1:0]  vd1_next;
    logic [tdsppm_pkg::DD_W-1:0]  dd1_next;
    logic [tdsppm_pkg::TA_W-1:0]  ta2_next;
    logic [tdsppm_pkg::TB_W-1:0]  tb2_next;
    logic [tdsppm_pkg::TL_W-1:0]  tl2_next;
    logic [tdsppm_pkg::D3_W-1:0]  d3_2_next;
    logic [tdsppm_pkg::PA_W-1:0]  pa3_next;
    logic [tdsppm_pkg::PB_W-1:0]  pb3_next;
    logic [tdsppm_pkg::DEN_W-1:0] den3_next;
    logic [tdsppm_pkg::CMP_W-1:0] diff4;
    logic [tdsppm_pkg::P_W-1:0]   p4_next;
    logic [tdsppm_pkg::MLO_W-1:0] mlo5_next;
    logic [tdsppm_pkg::MHI_W-1:0] mhi5_next;
    logic [tdsppm_pkg::NUM_W-1:0] num6_next;
    logic [tdsppm_pkg::T_W-1:0]   t7_next;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[N] = frac_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign sample_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= sample_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        // invalid temperature means the 25 C reference
        temp_sel = sample.temp_valid
                 ? {{2{sample.temp_sixteenths[tdsppm_pkg::TEMP_BITS-1]}},
                    sample.temp_sixteenths}
                 : TW2'(tdsppm_pkg::D_REF);
        d_s = temp_sel + TW2'(tdsppm_pkg::D_REF);
        if (!sample.volts_valid)
        begin
            st0_next = tdsppm_pkg::STAT_VOLT_BAD;
        end
        else if (d_s[TW2-1] || d_s == '0)
        begin
            st0_next = tdsppm_pkg::STAT_TEMP_BAD;
        end
        else
        begin
            st0_next = tdsppm_pkg::STAT_OK;
        end

        vv1_next  = tdsppm_pkg::VV_W'(v0_reg) * tdsppm_pkg::VV_W'(v0_reg);
        vd1_next  = tdsppm_pkg::VD_W'(v0_reg) * tdsppm_pkg::VD_W'(d0_reg);
        dd1_next  = tdsppm_pkg::DD_W'(d0_reg) * tdsppm_pkg::DD_W'(d0_reg);

        ta2_next  = tdsppm_pkg::TA_W'(coef.cubic) * tdsppm_pkg::TA_W'(vv1_reg);
        tb2_next  = tdsppm_pkg::TB_W'(coef.square) * tdsppm_pkg::TB_W'(vd1_reg);
        tl2_next  = tdsppm_pkg::TL_W'(coef.linear) * tdsppm_pkg::TL_W'(dd1_reg);
        d3_2_next = tdsppm_pkg::D3_W'(dd1_reg) * tdsppm_pkg::D3_W'(d1_reg);

        // 16*ta + 25*tl and 20*tb as shift-adds
        pa3_next  = (tdsppm_pkg::PA_W'(ta2_reg) << 4)
                  + (tdsppm_pkg::PA_W'(tl2_reg) << 4)
                  + (tdsppm_pkg::PA_W'(tl2_reg) << 3)
                  + tdsppm_pkg::PA_W'(tl2_reg);
        pb3_next  = (tdsppm_pkg::PB_W'(tb2_reg) << 4) + (tdsppm_pkg::PB_W'(tb2_reg) << 2);
        den3_next = tdsppm_pkg::DEN_W'(d3_2_reg)
                  * tdsppm_pkg::DEN_W'(tdsppm_pkg::DEN_SCALE);

        // a polynomial at or below zero gives zero ppm
        diff4 = tdsppm_pkg::CMP_W'(pa3_reg) - tdsppm_pkg::CMP_W'(pb3_reg);
        p4_next = (tdsppm_pkg::CMP_W'(pa3_reg) > tdsppm_pkg::CMP_W'(pb3_reg))
                ? diff4[tdsppm_pkg::P_W-1:0] : '0;

        mlo5_next = tdsppm_pkg::MLO_W'(v4_reg)
                  * tdsppm_pkg::MLO_W'(p4_reg[tdsppm_pkg::P_LO_W-1:0]);
        mhi5_next = tdsppm_pkg::MHI_W'(v4_reg)
                  * tdsppm_pkg::MHI_W'(p4_reg[tdsppm_pkg::P_W-1:tdsppm_pkg::P_LO_W]);

        num6_next = (tdsppm_pkg::NUM_W'(mhi5_reg) << tdsppm_pkg::P_LO_W)
                  + tdsppm_pkg::NUM_W'(mlo5_reg);

        // half of the divisor added for round to nearest
        t7_next   = (tdsppm_pkg::T_W'(num6_reg) << 1) + tdsppm_pkg::T_W'(den6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            v0_reg    <= sample.volts_mv;
            d0_reg    <= d_s[DB-1:0];
            st_reg[0] <= st0_next;
        end
        if (adv[1])
        begin
            v1_reg    <= v0_reg;
            d1_reg    <= d0_reg;
            vv1_reg   <= vv1_next;
            vd1_reg   <= vd1_next;
            dd1_reg   <= dd1_next;
            st_reg[1] <= st_reg[0];
        end
        if (adv[2])
        begin
            v2_reg    <= v1_reg;
            ta2_reg   <= ta2_next;
            tb2_reg   <= tb2_next;
            tl2_reg   <= tl2_next;
            d3_2_reg  <= d3_2_next;
            st_reg[2] <= st_reg[1];
        end
        if (adv[3])
        begin
            v3_reg    <= v2_reg;
            pa3_reg   <= pa3_next;
            pb3_reg   <= pb3_next;
            den3_reg  <= den3_next;
            st_reg[3] <= st_reg[2];
        end
        if (adv[4])
        begin
            v4_reg    <= v3_reg;
            p4_reg    <= p4_next;
            den4_reg  <= den3_reg;
            st_reg[4] <= st_reg[3];
        end
        if (adv[5])
        begin
            mlo5_reg  <= mlo5_next;
            mhi5_reg  <= mhi5_next;
            den5_reg  <= den4_reg;
            st_reg[5] <= st_reg[4];
        end
        if (adv[6])
        begin
            num6_reg  <= num6_next;
            den6_reg  <= den5_reg;
            st_reg[6] <= st_reg[5];
        end
        if (adv[7])
        begin
            t7_reg    <= t7_next;
            den7_reg  <= den6_reg;
            st_reg[7] <= st_reg[6];
        end
    end

    assign frac.t      = t7_reg;
    assign frac.den    = den7_reg;
    assign frac.status = st_reg[N-1];
    assign frac_valid  = vld_reg[N-1];

endmodule

@@ src/tdsppm_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with saturation
module tdsppm_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdsppm_pkg::frac_t     frac,
    input  logic                  frac_valid,
    output logic                  frac_ready,
    output logic [tdsppm_pkg::PPM_W-1:0]  ppm,
    output logic [tdsppm_pkg::STAT_W-1:0] status,
    output logic                  ppm_valid,
    input  logic                  ppm_ready
);

    localparam int N   = tdsppm_pkg::DIV_STAGES;
    localparam int QW  = tdsppm_pkg::PPM_W;
    localparam int RW  = tdsppm_pkg::R_W;
    localparam int D2W = tdsppm_pkg::DEN_W + 1;
    localparam int SW  = tdsppm_pkg::STAT_W;

    logic [N-1:0] vld_reg;
    logic [N:0]   adv;

    // stages 0..QW hold a partial remainder, the last one the result
    logic [RW-1:0]  rem_reg  [QW+1];
    logic [RW-1:0]  rem_next [QW+1];
    logic [QW-1:0]  quo_reg  [QW+1];
    logic [QW-1:0]  quo_next [QW+1];
    logic [D2W-1:0] d2_reg   [QW+1];
    logic [D2W-1:0] d2_next  [QW+1];
    logic [QW:0]    sat_reg;
    logic [QW:0]    sat_next;
    logic [SW-1:0]  st_reg   [N];
    logic [QW-1:0]  ppm_reg, ppm_next;
    logic [RW-1:0]  step [QW+1];
    logic [QW:0]    ge;

    always_comb
    begin
        adv[N] = ppm_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign frac_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= frac_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        // entry: quotient of 2^16 or more saturates
        rem_next[0] = RW'(frac.t);
        d2_next[0]  = {frac.den, 1'b0};
        quo_next[0] = '0;
        sat_next[0] = RW'(frac.t) >= (RW'(frac.den) << (QW + 1));
        step[0]     = '0;
        ge[0]       = 1'b0;
        for (int k = 1; k <= QW; k++)
        begin
            step[k]     = RW'(d2_reg[k-1]) << (QW - k);
            ge[k]       = rem_reg[k-1] >= step[k];
            rem_next[k] = ge[k] ? rem_reg[k-1] - step[k] : rem_reg[k-1];
            quo_next[k] = {quo_reg[k-1][QW-2:0], ge[k]};
            d2_next[k]  = d2_reg[k-1];
            sat_next[k] = sat_reg[k-1];
        end
        if (st_reg[QW] != tdsppm_pkg::STAT_OK)
        begin
            ppm_next = '0;
        end
        else if (sat_reg[QW])
        begin
            ppm_next = '1;
        end
        else
        begin
            ppm_next = quo_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            st_reg[0] <= frac.status;
        end
        for (int k = 0; k <= QW; k++)
        begin
            if (adv[k])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                d2_reg[k]  <= d2_next[k];
                sat_reg[k] <= sat_next[k];
            end
        end
        for (int k = 1; k < N; k++)
        begin
            if (adv[k])
            begin
                st_reg[k] <= st_reg[k-1];
            end
        end
        if (adv[N-1])
        begin
            ppm_reg <= ppm_next;
        end
    end

    assign ppm       = ppm_reg;
    assign status    = st_reg[N-1];
    assign ppm_valid = vld_reg[N-1];

endmodule

@@ src/tds_ppm_temperature_compensated_unit.sv @@
// top level: coefficient registers, polynomial pipeline and divider
// in total: 26 register stages between an accepted word and its shown result
// throughput: one word per cycle while result_ready holds, stages move independently so bubbles close up
// depth: 8 polynomial stages, then 18 divider stages (entry, 16 one-bit steps, output)
// reset: coefficients return to their defaults and all stages are emptied
module tds_ppm_temperature_compensated_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tdsppm_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [tdsppm_pkg::CFG_W-1:0]           cfg_wdata,
    input  tdsppm_pkg::sample_t                    sample,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    output tdsppm_pkg::result_t                    result,
    output logic                                   result_valid,
    input  logic                                   result_ready
);

    tdsppm_pkg::coef_t coef_reg;
    tdsppm_pkg::frac_t frac;
    logic              frac_valid;
    logic              frac_ready;
    logic [tdsppm_pkg::PPM_W-1:0]  ppm;
    logic [tdsppm_pkg::STAT_W-1:0] status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.cubic  <= tdsppm_pkg::CUBIC_RST;
            coef_reg.square <= tdsppm_pkg::SQUARE_RST;
            coef_reg.linear <= tdsppm_pkg::LINEAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tdsppm_pkg::REG_CUBIC:
                begin
                    coef_reg.cubic <= cfg_wdata[tdsppm_pkg::CUBIC_W-1:0];
                end
                tdsppm_pkg::REG_SQUARE:
                begin
                    coef_reg.square <= cfg_wdata[tdsppm_pkg::SQUARE_W-1:0];
                end
                tdsppm_pkg::REG_LINEAR:
                begin
                    coef_reg.linear <= cfg_wdata[tdsppm_pkg::LINEAR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    tdsppm_poly u_poly
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef         (coef_reg),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .frac         (frac),
        .frac_valid   (frac_valid),
        .frac_ready   (frac_ready)
    );

    tdsppm_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frac       (frac),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .ppm        (ppm),
        .status     (status),
        .ppm_valid  (result_valid),
        .ppm_ready  (result_ready)
    );

    // conductivity in uS/cm is twice the ppm figure
    assign result.ppm_out         = ppm;
    assign result.conductivity_us = {ppm, 1'b0};
    assign result.status          = status;

    a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != tdsppm_pkg::STAT_OK |-> result.ppm_out == '0)
        else $error("error status with nonzero ppm");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("input stalled while output side is free");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == tdsppm_pkg::STAT_OK
                      || result.status == tdsppm_pkg::STAT_VOLT_BAD
                      || result.status == tdsppm_pkg::STAT_TEMP_BAD)
        else $error("undefined status code on result");

endmodule
